[rtl/core/joystick_shaping_drive_mixer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the joystick shaping drive mixer
// Checks on the same edge and on the following edge. They expand to nothing
// when the design is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_SHAPING_DRIVE_MIXER_MACROS_SVH
`define JOYSTICK_SHAPING_DRIVE_MIXER_MACROS_SVH

`ifndef SYNTHESIS
`define JSDM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define JSDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define JSDM_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define JSDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/core/jsdm_pkg.sv]
// ----------------------------------------------------------------------------
// Joystick shaping drive mixer package
// Widths, constants, register indexes and the types shared by the sequencer
// and the shared multiply and divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jsdm_pkg;

   localparam logic [7:0] CENTRE = 8'd127;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int PCT_W       = 7;
   localparam int DEAD_W      = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_X_SCALE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_SCALE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND = 2'd3;

   localparam logic [PCT_W-1:0]  RESET_X_SCALE  = 7'd78;
   localparam logic [PCT_W-1:0]  RESET_Y_SCALE  = 7'd80;
   localparam logic [PCT_W-1:0]  RESET_RAMP     = 7'd100;
   localparam logic [DEAD_W-1:0] RESET_DEADBAND = 6'd8;

   localparam int OPA_W       = 12;
   localparam int OPB_W       = 8;
   localparam int PROD_W      = 20;
   localparam int RECIP_W     = 16;
   localparam int MUL_W       = PROD_W + RECIP_W;
   localparam int RECIP_SHIFT = 22;
   localparam int QUOT_W      = MUL_W - RECIP_SHIFT;

   localparam logic [RECIP_W-1:0] RECIP_100   = 16'd41943;
   localparam logic [RECIP_W-1:0] RECIP_127   = 16'd33025;
   localparam logic [6:0]         DIVISOR_100 = 7'd100;
   localparam logic [6:0]         DIVISOR_127 = 7'd127;

   localparam logic [OPA_W-1:0] RAMP_BIAS = 12'd2000;

   typedef enum logic {
      DIV_100,
      DIV_127
   } div_sel_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_MUL2,
      PH_FIX
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE_X,
      ST_CURVE_X,
      ST_SCALE_Y,
      ST_RAMP_Y,
      ST_RAMP_X,
      ST_OUTPUT
   } seq_state_type;

   typedef struct packed {
      logic              start;
      div_sel_type       div_sel;
      logic [OPA_W-1:0]  opa;
      logic [OPB_W-1:0]  opb;
   } unit_cmd_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } unit_rsp_type;

endpackage

`default_nettype wire

[rtl/core/joystick_shaping_drive_mixer.sv]
// ----------------------------------------------------------------------------
// Joystick shaping drive mixer
// Scales, curves, ramps and deadbands one joystick sample, then mixes it into
// left and right drive bytes.
//
// The req channel carries one raw x, y sample per item; the rsp channel
// returns the shaped axes and both drive bytes. Both use valid and stall.
// The csr channel writes the four gain and deadband registers; it is always
// ready. The user must see that it is written only while the block is idle;
// the block itself does not enforce this. One item runs as five operations
// on a single shared multiplier with a reciprocal divide, followed by a step
// that loads the output register.
// req_stall is high from acceptance until the result has been loaded.
// If rsp_stall holds the previous result, the block finishes its work and
// waits to load the new one; the held result does not change.
// Reset restores the register defaults, sets both ramp histories to centre
// and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "joystick_shaping_drive_mixer_macros.svh"

module joystick_shaping_drive_mixer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_raw_x,
   input  logic [7:0]                          req_raw_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_shaped_x,
   output logic [7:0]                          rsp_shaped_y,
   output logic [7:0]                          rsp_left_drive,
   output logic [7:0]                          rsp_right_drive,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [jsdm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [jsdm_pkg::CSR_DATA_W-1:0]     csr_data
);
   import jsdm_pkg::*;

   seq_state_type      state_ff, state_in;
   logic               issued_ff, issued_in;
   logic [7:0]         x_ff, x_in;
   logic [7:0]         y_ff, y_in;
   logic [7:0]         prev_x_ff, prev_x_in;
   logic [7:0]         prev_y_ff, prev_y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         out_x_ff, out_x_in;
   logic [7:0]         out_y_ff, out_y_in;
   logic [7:0]         out_left_ff, out_left_in;
   logic [7:0]         out_right_ff, out_right_in;

   logic [PCT_W-1:0]   x_scale_ff;
   logic [PCT_W-1:0]   y_scale_ff;
   logic [PCT_W-1:0]   ramp_ff;
   logic [DEAD_W-1:0]  dead_ff;

   unit_cmd_type       unit_cmd;
   unit_rsp_type       unit_rsp;

   function automatic logic [7:0] sat8(input logic signed [15:0] v);
      logic [7:0] r;
      if (v < 16'sd0) begin
         r = 8'd0;
      end else if (v > 16'sd255) begin
         r = 8'd255;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   function automatic logic [7:0] deadband(input logic [7:0] v, input logic [DEAD_W-1:0] h);
      logic [7:0] lo_th;
      logic [7:0] hi_th;
      logic [7:0] r;
      lo_th = CENTRE - 8'(h);
      hi_th = CENTRE + 8'(h);
      if (v < lo_th) begin
         r = v + 8'(h);
      end else if (v > hi_th) begin
         r = v - 8'(h);
      end else begin
         r = CENTRE;
      end
      return r;
   endfunction

   function automatic logic [7:0] clamp_mix(input logic signed [10:0] v);
      logic [7:0] r;
      if (v < 11'sd0) begin
         r = 8'd0;
      end else if (v > 11'sd254) begin
         r = 8'd254;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   jsdm_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (unit_cmd),
      .rsp   (unit_rsp)
   );

   always_comb begin
      logic               y_side;
      logic [7:0]         axis_v;
      logic [7:0]         prev_v;
      logic               lo;
      logic [7:0]         mag_scale;
      logic [7:0]         mag_curve;
      logic [OPA_W-1:0]   ramp_arg;
      logic [OPA_W-1:0]   ramp20;
      logic [PCT_W-1:0]   pct;
      logic signed [15:0] quot_s;
      logic signed [15:0] res_s;
      logic [7:0]         res8;
      logic [7:0]         db_x;
      logic [7:0]         db_y;
      logic signed [10:0] left_s;
      logic signed [10:0] right_s;

      y_side    = (state_ff == ST_SCALE_Y) || (state_ff == ST_RAMP_Y);
      axis_v    = y_side ? y_ff : x_ff;
      prev_v    = y_side ? prev_y_ff : prev_x_ff;
      lo        = axis_v < CENTRE;
      mag_scale = lo ? (8'd128 - axis_v) : (axis_v - CENTRE);
      mag_curve = lo ? (CENTRE - axis_v) : (axis_v - CENTRE);
      ramp_arg  = RAMP_BIAS + OPA_W'(axis_v) - OPA_W'(prev_v);
      ramp20    = (OPA_W'(ramp_ff) << 4) + (OPA_W'(ramp_ff) << 2);
      pct       = (state_ff == ST_SCALE_Y) ? y_scale_ff : x_scale_ff;
      quot_s    = $signed(16'(unit_rsp.quot));
      db_x      = deadband(x_ff, dead_ff);
      db_y      = deadband(y_ff, dead_ff);
      left_s    = $signed(11'(db_x)) + $signed(11'(db_y)) - 11'sd127;
      right_s   = $signed(11'(db_x)) - $signed(11'(db_y)) + 11'sd127;

      unit_cmd.start   = 1'b0;
      unit_cmd.div_sel = DIV_100;
      unit_cmd.opa     = OPA_W'(mag_scale);
      unit_cmd.opb     = OPB_W'(pct);
      res_s            = 16'sd0;

      case (state_ff)
         ST_SCALE_X, ST_SCALE_Y: begin
            res_s = lo ? (16'sd127 - quot_s) : (16'sd127 + quot_s);
         end
         ST_CURVE_X: begin
            unit_cmd.div_sel = DIV_127;
            unit_cmd.opa     = OPA_W'(mag_curve);
            unit_cmd.opb     = mag_curve;
            res_s = lo ? (16'sd127 + quot_s) : (16'sd128 - quot_s);
         end
         ST_RAMP_Y, ST_RAMP_X: begin
            unit_cmd.opa = ramp_arg;
            unit_cmd.opb = OPB_W'(ramp_ff);
            res_s = $signed(16'(prev_v)) + quot_s - $signed(16'(ramp20));
         end
         default: begin
            res_s = 16'sd0;
         end
      endcase
      res8 = sat8(res_s);

      state_in     = state_ff;
      issued_in    = issued_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_raw_x;
               y_in     = req_raw_y;
               state_in = ST_SCALE_X;
            end
         end
         ST_SCALE_X, ST_CURVE_X, ST_SCALE_Y, ST_RAMP_Y, ST_RAMP_X: begin
            unit_cmd.start = !issued_ff;
            if (!issued_ff) begin
               issued_in = 1'b1;
            end
            if (unit_rsp.done) begin
               issued_in = 1'b0;
               case (state_ff)
                  ST_SCALE_X: begin
                     x_in     = res8;
                     state_in = ST_CURVE_X;
                  end
                  ST_CURVE_X: begin
                     x_in     = res8;
                     state_in = ST_SCALE_Y;
                  end
                  ST_SCALE_Y: begin
                     y_in     = res8;
                     state_in = ST_RAMP_Y;
                  end
                  ST_RAMP_Y: begin
                     y_in      = res8;
                     prev_y_in = res8;
                     state_in  = ST_RAMP_X;
                  end
                  default: begin
                     x_in      = res8;
                     prev_x_in = res8;
                     state_in  = ST_OUTPUT;
                  end
               endcase
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_x_in     = db_x;
               out_y_in     = db_y;
               out_left_in  = clamp_mix(left_s);
               out_right_in = 8'd255 - clamp_mix(right_s);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in  = ST_IDLE;
            issued_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         prev_x_ff    <= CENTRE;
         prev_y_ff    <= CENTRE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff <= RESET_X_SCALE;
         y_scale_ff <= RESET_Y_SCALE;
         ramp_ff    <= RESET_RAMP;
         dead_ff    <= RESET_DEADBAND;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_X_SCALE:  x_scale_ff <= csr_data[PCT_W-1:0];
            CSR_Y_SCALE:  y_scale_ff <= csr_data[PCT_W-1:0];
            CSR_RAMP:     ramp_ff    <= csr_data[PCT_W-1:0];
            CSR_DEADBAND: dead_ff    <= csr_data[DEAD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready       = 1'b1;
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shaped_x    = out_x_ff;
   assign rsp_shaped_y    = out_y_ff;
   assign rsp_left_drive  = out_left_ff;
   assign rsp_right_drive = out_right_ff;

   `JSDM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "block not busy after taking an item")
   `JSDM_ASSERT_NOW(a_done_while_issued, clock, reset, unit_rsp.done, issued_ff, "unit result with no operation issued")
   `JSDM_ASSERT_NEXT(a_hold_until_free, clock, reset, (state_ff == ST_OUTPUT) && rsp_valid_ff && rsp_stall, state_ff == ST_OUTPUT, "result loaded over a stalled item")
   `JSDM_ASSERT_NOW(a_drive_range, clock, reset, rsp_valid, (rsp_left_drive != 8'd255) && (rsp_right_drive != 8'd0), "drive byte outside mix range")

endmodule

`default_nettype wire

[rtl/core/jsdm_muldiv.sv]
// ----------------------------------------------------------------------------
// Shared multiply and constant divide unit
// Forms floor(a*b/d) for d of 100 or 127 on one multiplier: the product first,
// then a reciprocal product, then a single correction step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "joystick_shaping_drive_mixer_macros.svh"

module jsdm_muldiv (
   input  logic                  clock,
   input  logic                  reset,
   input  jsdm_pkg::unit_cmd_type cmd,
   output jsdm_pkg::unit_rsp_type rsp
);
   import jsdm_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [MUL_W-1:0]     mul_ff, mul_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   div_sel_type          div_ff, div_in;
   logic                 done_ff, done_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;

   logic [PROD_W-1:0]    mul_a;
   logic [RECIP_W-1:0]   mul_b;
   logic [MUL_W-1:0]     product;
   logic [RECIP_W-1:0]   recip;
   logic [QUOT_W-1:0]    q0;
   logic [PROD_W:0]      div_ext;
   logic [PROD_W:0]      qd;
   logic [PROD_W:0]      rem;
   logic [QUOT_W-1:0]    quot_next;

   assign recip   = (div_ff == DIV_100) ? RECIP_100 : RECIP_127;
   assign div_ext = (div_ff == DIV_100) ? (PROD_W+1)'(DIVISOR_100) : (PROD_W+1)'(DIVISOR_127);

   assign mul_a   = (phase_ff == PH_MUL2) ? mul_ff[PROD_W-1:0] : PROD_W'(cmd.opa);
   assign mul_b   = (phase_ff == PH_MUL2) ? recip : RECIP_W'(cmd.opb);
   assign product = MUL_W'(mul_a) * MUL_W'(mul_b);

   assign q0        = mul_ff[RECIP_SHIFT +: QUOT_W];
   assign qd        = (div_ff == DIV_100) ? (PROD_W+1)'(q0) * (PROD_W+1)'(DIVISOR_100)
                                          : (PROD_W+1)'(q0) * (PROD_W+1)'(DIVISOR_127);
   assign rem       = {1'b0, prod_ff} - qd;
   assign quot_next = q0 + QUOT_W'(rem >= div_ext);

   always_comb begin
      phase_in = phase_ff;
      mul_in   = mul_ff;
      prod_in  = prod_ff;
      div_in   = div_ff;
      done_in  = 1'b0;
      quot_in  = quot_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (cmd.start) begin
               mul_in   = product;
               div_in   = cmd.div_sel;
               phase_in = PH_MUL2;
            end
         end
         PH_MUL2: begin
            prod_in  = mul_ff[PROD_W-1:0];
            mul_in   = product;
            phase_in = PH_FIX;
         end
         PH_FIX: begin
            quot_in  = quot_next;
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff  <= mul_in;
      prod_ff <= prod_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

   `JSDM_ASSERT_NOW(a_start_when_idle, clock, reset, cmd.start, phase_ff == PH_IDLE, "unit started while busy")
   `JSDM_ASSERT_NEXT(a_start_to_mul2, clock, reset, cmd.start, phase_ff == PH_MUL2, "unit did not advance after start")
   `JSDM_ASSERT_NEXT(a_fix_done, clock, reset, phase_ff == PH_FIX, done_ff, "no result after correction step")
   `JSDM_ASSERT_NOW(a_rem_bound, clock, reset, phase_ff == PH_FIX, rem < (div_ext + div_ext), "reciprocal estimate out by more than one")

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick shaping drive mixer testbench
// Feeds raw joystick samples through the block under a range of gain, ramp
// and deadband settings. A scoreboard predicts the shaped axes and both drive
// bytes, and checks every returned item against the oldest prediction.
// Both channels idle and stall at random. One phase holds the output side off
// for a long stretch, and one phase pauses the input until all items return.
// ----------------------------------------------------------------------------
module tb;
   import jsdm_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_HOLD   = 600;

   typedef struct packed {
      logic [7:0] shaped_x;
      logic [7:0] shaped_y;
      logic [7:0] left_drive;
      logic [7:0] right_drive;
   } drive_item_type;

   class drive_mix_checker;
      logic [PCT_W-1:0]  x_gain;
      logic [PCT_W-1:0]  y_gain;
      logic [PCT_W-1:0]  ramp_rate;
      logic [DEAD_W-1:0] dead_half;
      logic [7:0]        x_hist;
      logic [7:0]        y_hist;
      drive_item_type    expected_drives[$];
      int                errors;

      function new();
         x_gain    = RESET_X_SCALE;
         y_gain    = RESET_Y_SCALE;
         ramp_rate = RESET_RAMP;
         dead_half = RESET_DEADBAND;
         x_hist    = CENTRE;
         y_hist    = CENTRE;
         errors    = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_X_SCALE: begin
               x_gain = data;
            end
            CSR_Y_SCALE: begin
               y_gain = data;
            end
            CSR_RAMP: begin
               ramp_rate = data;
            end
            default: begin
               dead_half = data[DEAD_W-1:0];
            end
         endcase
      endfunction

      function int sat_byte(int v);
         if (v < 0) return 0;
         if (v > 255) return 255;
         return v;
      endfunction

      function int scale_deflection(int v, int pct);
         if (v < 127) return sat_byte(127 - (pct * (128 - v)) / 100);
         return sat_byte(127 + (pct * (v - 127)) / 100);
      endfunction

      function int invert_curve(int v);
         int t;
         int q;
         t = v - 127;
         q = (t * t) / 127;
         if (v < 127) return sat_byte(127 + q);
         return sat_byte(128 - q);
      endfunction

      function int ramp_toward(int target, int prev);
         int r;
         int step;
         r = ramp_rate;
         step = (r * (target - prev + 2000)) / 100 - 20 * r;
         return sat_byte(prev + step);
      endfunction

      function int dead_zone(int v);
         int h;
         h = dead_half;
         if (v < 127 - h) return v + h;
         if (v > 127 + h) return v - h;
         return 127;
      endfunction

      function int clamp_mix(int v);
         if (v < 0) return 0;
         if (v > 254) return 254;
         return v;
      endfunction

      function void note_sample(logic [7:0] raw_x, logic [7:0] raw_y);
         int x;
         int y;
         drive_item_type want;
         x = invert_curve(scale_deflection(raw_x, x_gain));
         y = scale_deflection(raw_y, y_gain);
         y = ramp_toward(y, y_hist);
         x = ramp_toward(x, x_hist);
         y_hist = y[7:0];
         x_hist = x[7:0];
         x = dead_zone(x);
         y = dead_zone(y);
         want.shaped_x    = x[7:0];
         want.shaped_y    = y[7:0];
         want.left_drive  = 8'(clamp_mix(x + y - 127));
         want.right_drive = 8'(255 - clamp_mix(x - y + 127));
         expected_drives.push_back(want);
      endfunction

      function void check_drive(drive_item_type got);
         drive_item_type want;
         if (expected_drives.size() == 0) begin
            $error("drive item returned with no sample pending");
            errors++;
            return;
         end
         want = expected_drives.pop_front();
         if (got.shaped_x !== want.shaped_x) begin
            $error("shaped_x: expected %0d, actual %0d", want.shaped_x, got.shaped_x);
            errors++;
         end
         if (got.shaped_y !== want.shaped_y) begin
            $error("shaped_y: expected %0d, actual %0d", want.shaped_y, got.shaped_y);
            errors++;
         end
         if (got.left_drive !== want.left_drive) begin
            $error("left_drive: expected %0d, actual %0d", want.left_drive, got.left_drive);
            errors++;
         end
         if (got.right_drive !== want.right_drive) begin
            $error("right_drive: expected %0d, actual %0d", want.right_drive,
                   got.right_drive);
            errors++;
         end
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_raw_x;
   logic [7:0]             req_raw_y;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [7:0]             rsp_shaped_x;
   logic [7:0]             rsp_shaped_y;
   logic [7:0]             rsp_left_drive;
   logic [7:0]             rsp_right_drive;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   drive_mix_checker drive_check = new();
   bit               rsp_idle_on = 1'b1;
   int               rsp_hold_len = 0;
   int               quiet_cycles = 0;
   logic [7:0]       last_x = 8'd127;
   logic [7:0]       last_y = 8'd127;

   joystick_shaping_drive_mixer i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_shaped_x    (rsp_shaped_x),
      .rsp_shaped_y    (rsp_shaped_y),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL joystick_shaping_drive_mixer");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int             n;
      drive_item_type got;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         n = rsp_idle_on ? $urandom_range(0, 17) : 0;
         if (rsp_hold_len > 0) begin
            n = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         got.shaped_x    = rsp_shaped_x;
         got.shaped_y    = rsp_shaped_y;
         got.left_drive  = rsp_left_drive;
         got.right_drive = rsp_right_drive;
         drive_check.check_drive(got);
      end
   end

   task automatic offer_sample(input logic [7:0] x, input logic [7:0] y, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_raw_x <= 8'($urandom);
         req_raw_y <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_x <= x;
      req_raw_y <= y;
      do @(posedge clock); while (!(req_valid && !req_stall));
      drive_check.note_sample(x, y);
      last_x = x;
      last_y = y;
   endtask

   task automatic drain_samples();
      req_valid <= 1'b0;
      while (drive_check.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      drive_check.set_register(idx, data);
   endtask

   task automatic apply_setting(input logic [6:0] xs, input logic [6:0] ys,
                                input logic [6:0] rp, input logic [6:0] db);
      drain_samples();
      write_register(CSR_X_SCALE, xs);
      write_register(CSR_Y_SCALE, ys);
      write_register(CSR_RAMP, rp);
      write_register(CSR_DEADBAND, db);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [6:0] pick_percent(int lowest);
      int w;
      w = $urandom_range(0, 7);
      if (w == 0) return 7'd0;
      if (w == 1) return 7'd127;
      if (w == 2) return 7'($urandom_range(101, 127));
      return 7'($urandom_range(lowest, 100));
   endfunction

   function automatic logic [6:0] pick_deadband();
      int w;
      w = $urandom_range(0, 7);
      if (w == 0) return 7'd0;
      if (w == 1) return 7'($urandom_range(0, 127));
      return 7'($urandom_range(1, 20));
   endfunction

   function automatic logic [7:0] pick_axis(logic [7:0] last);
      int w;
      w = $urandom_range(0, 9);
      if (w < 5) return 8'($urandom_range(0, 255));
      if (w < 7) return 8'($urandom_range(100, 154));
      if (w == 7) begin
         if ($urandom_range(0, 1) == 1) return 8'(255 - $urandom_range(0, 1));
         return 8'($urandom_range(0, 1));
      end
      return last;
   endfunction

   initial begin
      int gap;
      bit req_idle_on;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_raw_x <= 8'd0;
      req_raw_y <= 8'd0;
      csr_valid <= 1'b0;
      csr_index <= CSR_X_SCALE;
      csr_data  <= 7'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_sample(8'd127, 8'd127, 0);
      offer_sample(8'd0, 8'd0, 0);
      offer_sample(8'd255, 8'd255, 3);
      offer_sample(8'd0, 8'd255, 0);
      offer_sample(8'd255, 8'd0, 5);
      offer_sample(8'd126, 8'd128, 0);
      offer_sample(8'd128, 8'd126, 0);

      apply_setting(7'd127, 7'd127, 7'd100, 7'd0);
      offer_sample(8'd0, 8'd255, 0);
      offer_sample(8'd255, 8'd0, 0);
      offer_sample(8'd0, 8'd0, 2);
      offer_sample(8'd255, 8'd255, 0);

      apply_setting(7'd0, 7'd0, 7'd0, 7'd127);
      offer_sample(8'd0, 8'd0, 0);
      offer_sample(8'd255, 8'd255, 0);

      apply_setting(7'd100, 7'd100, 7'd127, 7'd0);
      offer_sample(8'd0, 8'd0, 0);
      offer_sample(8'd255, 8'd255, 0);
      offer_sample(8'd0, 8'd255, 1);
      offer_sample(8'd255, 8'd0, 0);

      apply_setting(7'd100, 7'd100, 7'd1, 7'd64);
      offer_sample(8'd255, 8'd255, 0);
      offer_sample(8'd0, 8'd0, 0);

      for (int phase = 0; phase < 12; phase++) begin
         apply_setting(pick_percent(0), pick_percent(0), pick_percent(20), pick_deadband());
         req_idle_on = (phase % 3 != 0);
         rsp_idle_on = (phase % 4 != 1);
         if (phase == 4) rsp_hold_len = LONG_HOLD;
         for (int i = 0; i < 160; i++) begin
            if (phase == 7 && i == 80) drain_samples();
            gap = req_idle_on ? $urandom_range(0, 17) : 0;
            offer_sample(pick_axis(last_x), pick_axis(last_y), gap);
         end
      end

      drain_samples();
      repeat (60) @(posedge clock);
      if (drive_check.errors == 0 && drive_check.pending() == 0) begin
         $display("PASS joystick_shaping_drive_mixer");
      end else begin
         $display("FAIL joystick_shaping_drive_mixer");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/jsdm_pkg.sv
rtl/core/jsdm_muldiv.sv
rtl/core/joystick_shaping_drive_mixer.sv
test/tb.sv
